>>> rtl/scp_pkg.sv
// Package with the widths, payload types and register codes of the sphere collision block.
`default_nettype none
package scp_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned MAG_W     = 31;
  localparam int unsigned SQ_W      = 2 * MAG_W;
  localparam int unsigned NUM_W     = SQ_W + 1;
  localparam int unsigned ROOT_W    = MAG_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [MAG_W-1:0] RADIUS_RESET = MAG_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTRE_X = 2'd0,
    CFG_CENTRE_Y = 2'd1,
    CFG_CENTRE_Z = 2'd2,
    CFG_RADIUS   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      batch_last_in;
  } scp_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W-1:0] new_y;
    logic signed [COORD_W-1:0] new_z;
    logic                      inside_res;
    logic [MAG_W-1:0]          depth;
    logic                      batch_last_out;
  } scp_out_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] pos;
    logic                    last;
    logic [2:0]              neg;
    logic [2:0][MAG_W-1:0]   mag;
    logic                    hit;
  } scp_sb_t;

  typedef struct packed {
    scp_sb_t           sb;
    logic [ROOT_W-1:0] root_len;
  } scp_sbd_t;

endpackage
`default_nettype wire

>>> rtl/scp_stream_if.sv
// Valid/ready stream interfaces for the particle requests and the results.
`default_nettype none
interface scp_in_if import scp_pkg::*;;
  logic    valid;
  logic    ready;
  scp_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scp_out_if import scp_pkg::*;;
  logic     valid;
  logic     ready;
  scp_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/scp_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
`default_nettype none
module scp_sqrt import scp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [SQ_W-1:0]   rad_i,
  output logic      [ROOT_W-1:0] root_o
);

  localparam int unsigned REM_W = ROOT_W + 2;

  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SQ_W-1:0]   rad_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SQ_W-1:0]   rad_in;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    assign cur   = {rem_in, rad_in[SQ_W-1-2*k -: 2]};
    assign trial = {{(REM_W-ROOT_W){1'b0}}, root_in, 2'b01};
    assign diff  = cur - trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cur >= trial) begin
          rem_q[k]  <= diff[REM_W-1:0];
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= cur[REM_W-1:0];
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
        rad_q[k] <= rad_in;
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule
`default_nettype wire

>>> rtl/scp_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module scp_div import scp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [ROOT_W-1:0] den_i,
  output logic      [ROOT_W-1:0] quo_o
);

  localparam int unsigned REM_W = NUM_W - ROOT_W;

  logic [REM_W-1:0]  rem_q [ROOT_W];
  logic [ROOT_W-1:0] quo_q [ROOT_W];
  logic [NUM_W-1:0]  num_q [ROOT_W];
  logic [ROOT_W-1:0] den_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] quo_in;
    logic [NUM_W-1:0]  num_in;
    logic [ROOT_W-1:0] den_in;
    logic [REM_W:0]    cur;
    logic [REM_W:0]    den_x;
    logic [REM_W:0]    diff;

    if (k == 0) begin : g_first
      assign rem_in = num_i[NUM_W-1:ROOT_W];
      assign quo_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign cur   = {rem_in, num_in[ROOT_W-1-k]};
    assign den_x = {{(REM_W+1-ROOT_W){1'b0}}, den_in};
    assign diff  = cur - den_x;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cur >= den_x) begin
          rem_q[k] <= diff[REM_W-1:0];
          quo_q[k] <= {quo_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= cur[REM_W-1:0];
          quo_q[k] <= {quo_in[ROOT_W-2:0], 1'b0};
        end
        num_q[k] <= num_in;
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[ROOT_W-1];

endmodule
`default_nettype wire

>>> rtl/sphere_collision_projection_top.sv
// A request passes stages A, B and C, the square root, stages D and E, the divider and the output register.
// Throughput: one request per cycle; the whole pipeline stalls together when
// the output register holds a result that is not taken.
// The depth is set by the 31-stage square root and the 31-stage divider.
// Reset clears all valid bits and loads centre 0 and radius 1.0.
`default_nettype none
module sphere_collision_projection_top import scp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  scp_in_if.sink                    in_i,
  scp_out_if.source                 out_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [COORD_W-1:0]   cfg_wdata_i
);

  localparam logic signed [COORD_W+1:0] SAT_MAX = (COORD_W+2)'(64'sd2147483647);
  localparam logic signed [COORD_W+1:0] SAT_MIN = -(COORD_W+2)'(64'sd2147483648);

  logic [2:0][COORD_W-1:0] cen_q;
  logic [MAG_W-1:0]        rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q <= '0;
      rad_q <= RADIUS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTRE_X: cen_q[0] <= cfg_wdata_i;
        CFG_CENTRE_Y: cen_q[1] <= cfg_wdata_i;
        CFG_CENTRE_Z: cen_q[2] <= cfg_wdata_i;
        CFG_RADIUS:   rad_q    <= cfg_wdata_i[MAG_W-1:0];
        default:      ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // Stage A: offsets from the centre, their magnitudes and the per-axis radius test.
  logic [2:0][COORD_W-1:0] pos_in;
  logic [2:0][COORD_W:0]   d_a;
  logic [2:0][COORD_W:0]   m_a;
  logic [2:0]              lt_a;
  assign pos_in = {in_i.data.pos_z, in_i.data.pos_y, in_i.data.pos_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_a[i]  = {pos_in[i][COORD_W-1], pos_in[i]} - {cen_q[i][COORD_W-1], cen_q[i]};
      m_a[i]  = d_a[i][COORD_W] ? -d_a[i] : d_a[i];
      lt_a[i] = m_a[i] < {2'b00, rad_q};
    end
  end

  logic    va_q, vb_q, vc_q, vd_q, ve_q, vo_q;
  scp_sb_t sa_q, sb_q, sc_q;
  logic    cand_a_q, cand_b_q;
  logic [2:0][SQ_W-1:0] sq_b_q;
  logic [SQ_W-1:0]      rr_b_q;
  logic [SQ_W-1:0]      s_c_q;

  logic [SQ_W+1:0] s_sum;
  assign s_sum = {2'b00, sq_b_q[0]} + {2'b00, sq_b_q[1]} + {2'b00, sq_b_q[2]};

  scp_sb_t sc_d;
  always_comb begin
    sc_d     = sb_q;
    sc_d.hit = cand_b_q && (s_sum < {2'b00, rr_b_q});
  end

  logic [ROOT_W-1:0] root;
  logic              vs_q [ROOT_W];
  scp_sb_t           ss_q [ROOT_W];

  scp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (s_c_q),
    .root_o (root)
  );

  scp_sbd_t             sd_q, se_q;
  logic [2:0][SQ_W-1:0] prod_d_q;
  logic [2:0][NUM_W-1:0] num_e_q;

  logic [2:0][ROOT_W-1:0] quo;
  logic                   vq_q [ROOT_W];
  scp_sbd_t               sq_q [ROOT_W];

  for (genvar i = 0; i < 3; i++) begin : g_div
    scp_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_e_q[i]),
      .den_i (se_q.root_len),
      .quo_o (quo[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vo_q <= 1'b0;
      for (int k = 0; k < ROOT_W; k++) begin
        vs_q[k] <= 1'b0;
        vq_q[k] <= 1'b0;
      end
    end else if (en) begin
      va_q    <= in_i.valid;
      vb_q    <= va_q;
      vc_q    <= vb_q;
      vs_q[0] <= vc_q;
      for (int k = 1; k < ROOT_W; k++) begin
        vs_q[k] <= vs_q[k-1];
        vq_q[k] <= vq_q[k-1];
      end
      vd_q    <= vs_q[ROOT_W-1];
      ve_q    <= vd_q;
      vq_q[0] <= ve_q;
      vo_q    <= vq_q[ROOT_W-1];
    end
  end
  assign out_valid_q = vo_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sa_q.pos[i] <= pos_in[i];
        sa_q.neg[i] <= d_a[i][COORD_W];
        sa_q.mag[i] <= m_a[i][MAG_W-1:0];
      end
      sa_q.last <= in_i.data.batch_last_in;
      sa_q.hit  <= 1'b0;
      cand_a_q  <= &lt_a;

      sb_q     <= sa_q;
      cand_b_q <= cand_a_q;
      for (int i = 0; i < 3; i++) begin
        sq_b_q[i] <= sa_q.mag[i] * sa_q.mag[i];
      end
      rr_b_q <= rad_q * rad_q;

      sc_q  <= sc_d;
      s_c_q <= s_sum[SQ_W-1:0];

      ss_q[0] <= sc_q;
      for (int k = 1; k < ROOT_W; k++) begin
        ss_q[k] <= ss_q[k-1];
        sq_q[k] <= sq_q[k-1];
      end

      sd_q.sb       <= ss_q[ROOT_W-1];
      sd_q.root_len <= root;
      for (int i = 0; i < 3; i++) begin
        prod_d_q[i] <= ss_q[ROOT_W-1].mag[i] * rad_q;
      end

      se_q <= sd_q;
      for (int i = 0; i < 3; i++) begin
        num_e_q[i] <= {1'b0, prod_d_q[i]} +
            {{(NUM_W-ROOT_W+1){1'b0}}, sd_q.root_len[ROOT_W-1:1]};
      end

      sq_q[0] <= se_q;
    end
  end

  // Output stage: for a hit at a nonzero distance, apply the radial offset and saturate; else keep the position.
  scp_sbd_t                f_sb;
  logic [2:0][COORD_W-1:0] new_pos;
  logic signed [COORD_W+1:0] sum_f [3];
  logic                    moved;
  scp_out_t                res_d;
  scp_out_t                res_q;

  assign f_sb  = sq_q[ROOT_W-1];
  assign moved = f_sb.sb.hit && (f_sb.root_len != '0);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_f[i] = {{2{cen_q[i][COORD_W-1]}}, cen_q[i]};
      if (f_sb.sb.neg[i]) begin
        sum_f[i] = sum_f[i] - $signed({3'b000, quo[i]});
      end else begin
        sum_f[i] = sum_f[i] + $signed({3'b000, quo[i]});
      end
      if (!moved) begin
        new_pos[i] = f_sb.sb.pos[i];
      end else if (sum_f[i] > SAT_MAX) begin
        new_pos[i] = SAT_MAX[COORD_W-1:0];
      end else if (sum_f[i] < SAT_MIN) begin
        new_pos[i] = SAT_MIN[COORD_W-1:0];
      end else begin
        new_pos[i] = sum_f[i][COORD_W-1:0];
      end
    end
    res_d.new_x          = new_pos[0];
    res_d.new_y          = new_pos[1];
    res_d.new_z          = new_pos[2];
    res_d.inside_res     = f_sb.sb.hit;
    res_d.depth          = f_sb.sb.hit ? (rad_q - f_sb.root_len) : '0;
    res_d.batch_last_out = f_sb.sb.last;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = res_q;

endmodule
`default_nettype wire
